@@ rtl/core/erp_pkg.sv @@
`timescale 1ns / 1ps

package erp_pkg;

  localparam int unsigned SectorBytesDef = 4096;
  localparam int unsigned TotalBytesDef  = 67108864;

  localparam int unsigned StartW = 26;
  localparam int unsigned EndW   = 27;
  localparam int unsigned StateW = 28;

  localparam logic [StateW-1:0] Blk32Bytes = StateW'(32 * 1024);
  localparam logic [StateW-1:0] Blk64Bytes = StateW'(64 * 1024);

  typedef enum logic {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_4K   = 2'd1,
    KIND_32K  = 2'd2,
    KIND_64K  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_PANIC  = 2'd2,
    ST_IDLE   = 2'd3
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [StartW-1:0] start_addr;
    logic [EndW-1:0]   end_addr;
  } item_t;

  typedef struct packed {
    kind_e             kind;
    logic [StartW-1:0] addr;
    status_e           status;
    logic              last;
  } result_t;

endpackage

@@ rtl/core/erp_in_reg.sv @@
`timescale 1ns / 1ps

module erp_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  erp_pkg::item_t item_i,
  input  logic           take_i,
  output logic           in_stall_o,
  output logic           valid_o,
  output erp_pkg::item_t item_o
);
  import erp_pkg::*;

  logic  valid_d, valid_q;
  item_t item_q;
  logic  load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/core/erp_step.sv @@
`timescale 1ns / 1ps

module erp_step #(
  parameter int unsigned SECTOR_BYTES = erp_pkg::SectorBytesDef,
  parameter int unsigned TOTAL_BYTES  = erp_pkg::TotalBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  erp_pkg::item_t   item_i,
  output erp_pkg::result_t result_o
);
  import erp_pkg::*;

  localparam logic [StateW-1:0] SecBytes  = StateW'(SECTOR_BYTES);
  localparam logic [StateW-1:0] SecMask   = StateW'(SECTOR_BYTES - 1);
  localparam logic [StateW-1:0] Blk32Mask = Blk32Bytes - StateW'(1);
  localparam logic [StateW-1:0] Blk64Mask = Blk64Bytes - StateW'(1);
  localparam logic [StateW-1:0] TotalLim  = StateW'(TOTAL_BYTES);

  logic [StateW-1:0] cursor_d, cursor_q;
  logic [StateW-1:0] end_d, end_q;
  logic              busy_d, busy_q;

  logic [StateW-1:0] s_ext, e_ext, a_rnd, e_up, e_fin;
  logic [StateW-1:0] rem, step_size, cursor_nxt;
  kind_e             step_kind;
  logic              step_ok;
  result_t           res;

  always_comb begin
    s_ext = {{(StateW-StartW){1'b0}}, item_i.start_addr};
    e_ext = {{(StateW-EndW){1'b0}}, item_i.end_addr};
    a_rnd = s_ext & ~SecMask;
    if ((e_ext & SecMask) != '0) begin
      e_up = (e_ext & ~SecMask) + SecBytes;
    end else begin
      e_up = e_ext;
    end
    if (a_rnd == e_up) begin
      e_fin = e_up + SecBytes;
    end else begin
      e_fin = e_up;
    end
  end

  always_comb begin
    rem = end_q - cursor_q;
    step_ok = 1'b1;
    if (rem >= Blk64Bytes && (cursor_q & Blk64Mask) == '0) begin
      step_kind = KIND_64K;
      step_size = Blk64Bytes;
    end else if (rem >= Blk32Bytes && (cursor_q & Blk32Mask) == '0) begin
      step_kind = KIND_32K;
      step_size = Blk32Bytes;
    end else if (rem >= SecBytes && (cursor_q & SecMask) == '0) begin
      step_kind = KIND_4K;
      step_size = SecBytes;
    end else begin
      step_kind = KIND_NONE;
      step_size = '0;
      step_ok   = 1'b0;
    end
    cursor_nxt = cursor_q + step_size;
  end

  always_comb begin
    cursor_d = cursor_q;
    end_d    = end_q;
    busy_d   = busy_q;
    res      = '{kind: KIND_NONE, addr: '0, status: ST_IDLE, last: 1'b0};
    if (item_i.op == OP_START) begin
      res.addr = a_rnd[StartW-1:0];
      if (e_fin > TotalLim) begin
        busy_d     = 1'b0;
        res.status = ST_RANGE;
        res.last   = 1'b1;
      end else begin
        cursor_d   = a_rnd;
        end_d      = e_fin;
        busy_d     = a_rnd < e_fin;
        res.status = ST_OK;
        res.last   = !(a_rnd < e_fin);
      end
    end else if (busy_q) begin
      res.addr = cursor_q[StartW-1:0];
      if (step_ok) begin
        cursor_d   = cursor_nxt;
        busy_d     = cursor_nxt < end_q;
        res.kind   = step_kind;
        res.status = ST_OK;
        res.last   = !(cursor_nxt < end_q);
      end else begin
        busy_d     = 1'b0;
        res.status = ST_PANIC;
        res.last   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      end_q    <= '0;
      busy_q   <= 1'b0;
    end else if (fire_i) begin
      cursor_q <= cursor_d;
      end_q    <= end_d;
      busy_q   <= busy_d;
    end
  end

  assign result_o = res;

  // While a range is pending, the cursor stays sector aligned and below the end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ((cursor_q & SecMask) == '0 && cursor_q < end_q))
    else $error("pending range has a misaligned or exhausted cursor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (end_q <= TotalLim && (end_q & SecMask) == '0))
    else $error("pending range end is beyond flash or misaligned");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.op == OP_NEXT && busy_q) |-> (res.status != ST_PANIC))
    else $error("erase command planning reached the panic path");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res.last) |=> !busy_q)
    else $error("range still pending after its last transfer");

endmodule

@@ rtl/core/erp_out_reg.sv @@
`timescale 1ns / 1ps

module erp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  erp_pkg::result_t result_i,
  input  logic             out_stall_i,
  output logic             take_o,
  output logic             out_valid_o,
  output erp_pkg::result_t result_o
);
  import erp_pkg::*;

  logic    valid_d, valid_q;
  result_t result_q;

  assign take_o  = valid_i && (!valid_q || !out_stall_i);
  assign valid_d = take_o || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

@@ rtl/core/erase_range_planner.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// input    in         in_valid_i / in_stall_o   operation_i, start_addr_i, end_addr_i
// output   out        out_valid_o / out_stall_i erase_kind_o, erase_addr_o, status_o, last_o
//
// Every transfer in produces exactly one transfer out, through the input register and then the result register.
// One item is taken per cycle while the output does not stall; the limit is the single
// planning stage that updates the cursor and end registers before the next item reads them.
// Reset clears the cursor, the end, the pending flag and both valid flags.
// A stall on the output holds the result register and then the input register.

module erase_range_planner #(
  parameter int unsigned SECTOR_BYTES = erp_pkg::SectorBytesDef,
  parameter int unsigned TOTAL_BYTES  = erp_pkg::TotalBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [25:0] start_addr_i,
  input  logic [26:0] end_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  erase_kind_o,
  output logic [25:0] erase_addr_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  import erp_pkg::*;

  item_t   in_item, held_item;
  logic    held_valid;
  logic    take;
  result_t step_res, out_res;

  assign in_item = '{op: op_e'(operation_i), start_addr: start_addr_i, end_addr: end_addr_i};

  erp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .item_i     (in_item),
    .take_i     (take),
    .in_stall_o (in_stall_o),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  erp_step #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .TOTAL_BYTES  (TOTAL_BYTES)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (take),
    .item_i   (held_item),
    .result_o (step_res)
  );

  erp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (held_valid),
    .result_i    (step_res),
    .out_stall_i (out_stall_i),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .result_o    (out_res)
  );

  assign erase_kind_o = out_res.kind;
  assign erase_addr_o = out_res.addr;
  assign status_o     = out_res.status;
  assign last_o       = out_res.last;

endmodule
